// ===== hdl/rtwe_pkg.sv =====
// Shared types, codes and constants of the reliable transport window engine.
package rtwe_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_INIT_SEND_SEQ = 3'd0;
  localparam logic [2:0] REG_INIT_EXP_SEQ  = 3'd1;
  localparam logic [2:0] REG_WINDOW_BYTES  = 3'd2;
  localparam logic [2:0] REG_DUP_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_MAX_SEGMENT   = 3'd4;

  // Reset values of the configuration and sequence state.
  localparam logic [31:0] RST_INIT_SEND_SEQ = 32'd100;
  localparam logic [31:0] RST_INIT_EXP_SEQ  = 32'd0;
  localparam logic [15:0] RST_WINDOW_BYTES  = 16'd20240;
  localparam logic [3:0]  RST_DUP_THRESHOLD = 4'd3;
  localparam logic [10:0] RST_MAX_SEGMENT   = 11'd1012;
  localparam logic [3:0]  DUP_MAX           = 4'd15;

  // Input item kinds.
  localparam logic [1:0] FUNC_HEADER  = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_SEND    = 2'd2;

  // Result actions.
  localparam logic [1:0] ACT_SEND     = 2'd0;
  localparam logic [1:0] ACT_RETX     = 2'd1;
  localparam logic [1:0] ACT_DELIVER  = 2'd2;
  localparam logic [1:0] ACT_PURE_ACK = 2'd3;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_DUP,
    CMD_SCAN_OLD,
    CMD_EMIT_OLD,
    CMD_SCAN_ACK,
    CMD_SCAN_STORE,
    CMD_WRITE_STORE,
    CMD_SCAN_DELIV,
    CMD_EMIT_DELIV,
    CMD_SCAN_SEND,
    CMD_EMIT_SEND,
    CMD_FINISH
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic found;
    logic fire;
    logic is_hdr;
    logic store_ok;
    logic emit_ok;
  } status_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seg_seq;
    logic [10:0] seg_length;
    logic [31:0] ack_num;
    logic [15:0] send_room;
  } result_t;

  // Serial-number compare: a lies behind b.
  function automatic logic behind(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

// ===== hdl/rtwe_ctrl.sv =====
// Sequencing controller of the reliable transport window engine.
module rtwe_ctrl
  import rtwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  logic       in_ack_flag,
  input  status_t    st,
  output logic       in_ready,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DUP, S_OLD_SCAN, S_OLD_EMIT, S_ACK_SCAN, S_STORE_SCAN, S_STORE_WR,
    S_DELIV_SCAN, S_DELIV_EMIT, S_SEND_SCAN, S_SEND_EMIT, S_FINISH
  } state_t;

  state_t state;

  // State register and sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_func == FUNC_HEADER && in_ack_flag) state <= S_DUP;
            else if (in_func == FUNC_TIMEOUT) state <= S_OLD_SCAN;
            else if (in_func == FUNC_SEND) state <= S_SEND_SCAN;
          end
        end
        S_DUP: state <= st.fire ? S_OLD_SCAN : S_ACK_SCAN;
        S_OLD_SCAN: if (st.scan_done) state <= S_OLD_EMIT;
        S_OLD_EMIT: if (st.emit_ok) state <= st.is_hdr ? S_ACK_SCAN : S_FINISH;
        S_ACK_SCAN: begin
          if (st.scan_done) state <= st.store_ok ? S_STORE_SCAN : S_DELIV_SCAN;
        end
        S_STORE_SCAN: if (st.scan_done) state <= S_STORE_WR;
        S_STORE_WR: state <= S_DELIV_SCAN;
        S_DELIV_SCAN: begin
          if (st.scan_done) state <= st.found ? S_DELIV_EMIT : S_FINISH;
        end
        S_DELIV_EMIT: if (st.emit_ok) state <= S_DELIV_SCAN;
        S_SEND_SCAN: if (st.scan_done) state <= S_SEND_EMIT;
        S_SEND_EMIT: if (st.emit_ok) state <= S_FINISH;
        S_FINISH: if (st.emit_ok) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  // Command decode.
  always_comb begin
    unique case (state)
      S_DUP:        cmd = CMD_DUP;
      S_OLD_SCAN:   cmd = CMD_SCAN_OLD;
      S_OLD_EMIT:   cmd = CMD_EMIT_OLD;
      S_ACK_SCAN:   cmd = CMD_SCAN_ACK;
      S_STORE_SCAN: cmd = CMD_SCAN_STORE;
      S_STORE_WR:   cmd = CMD_WRITE_STORE;
      S_DELIV_SCAN: cmd = CMD_SCAN_DELIV;
      S_DELIV_EMIT: cmd = CMD_EMIT_DELIV;
      S_SEND_SCAN:  cmd = CMD_SCAN_SEND;
      S_SEND_EMIT:  cmd = CMD_EMIT_SEND;
      S_FINISH:     cmd = CMD_FINISH;
      default:      cmd = CMD_NONE;
    endcase
  end

endmodule

// ===== hdl/rtwe_datapath.sv =====
// Tables, counters, scan unit and result registers of the window engine.
module rtwe_datapath
  import rtwe_pkg::*;
#(
  parameter int SEND_SLOTS = 32,
  parameter int RECV_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic        in_accept,
  input  logic [87:0] in_data,
  input  logic [1:0]  in_user,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [95:0] out_data,
  output logic [1:0]  out_user,
  output logic        out_last
);

  localparam int SCAN_N = (SEND_SLOTS > RECV_SLOTS) ? SEND_SLOTS : RECV_SLOTS;
  localparam int IDXW   = $clog2(SCAN_N);
  localparam int SW     = $clog2(SEND_SLOTS);
  localparam int RW     = $clog2(RECV_SLOTS);

  // Configuration.
  logic [15:0] window_bytes;
  logic [3:0]  dup_threshold;
  logic [10:0] max_segment;

  // Tables.
  logic [31:0] send_seq [SEND_SLOTS];
  logic [10:0] send_len [SEND_SLOTS];
  logic [SEND_SLOTS-1:0] send_vld;
  logic [31:0] recv_seq [RECV_SLOTS];
  logic [10:0] recv_len [RECV_SLOTS];
  logic [RECV_SLOTS-1:0] recv_vld;

  // Scalar state.
  logic [15:0] send_bytes, recv_bytes;
  logic [31:0] expected_seq, next_seq, last_ack;
  logic [3:0]  dup_count;

  // Latched item.
  logic [1:0]  it_func;
  logic [31:0] it_ack, it_seq;
  logic [10:0] it_rxlen, it_txlen;

  // Scan unit.
  logic [IDXW-1:0] cnt, idx;
  logic            found, flag;
  logic [31:0]     best_gap, cap_seq;
  logic [10:0]     cap_len;

  // Result staging.
  logic    pend_valid;
  result_t pend, out_res, res;
  logic    push, flush, go, out_free;

  // Current scan entry.
  logic [SW-1:0] si;
  logic [RW-1:0] ri;
  logic          s_in, r_in, sv, rv, first, fcur, gcur, is_scan, scan_done;
  logic [31:0]   sseq, rseq, d;
  logic [10:0]   slen, rlen;
  logic          take_old, ack_drop, st_dup, st_free, stale, hit, sd_free;

  assign si    = cnt[SW-1:0];
  assign ri    = cnt[RW-1:0];
  assign s_in  = {1'b0, cnt} < (IDXW + 1)'(SEND_SLOTS);
  assign r_in  = {1'b0, cnt} < (IDXW + 1)'(RECV_SLOTS);
  assign sseq  = send_seq[si];
  assign slen  = send_len[si];
  assign rseq  = recv_seq[ri];
  assign rlen  = recv_len[ri];
  assign sv    = s_in && send_vld[si];
  assign rv    = r_in && recv_vld[ri];
  assign first = (cnt == '0);
  assign fcur  = first ? 1'b0 : found;
  assign gcur  = first ? 1'b0 : flag;
  assign d     = next_seq - sseq;

  assign take_old = sv && (!fcur || d > best_gap);
  assign ack_drop = sv && behind(sseq, it_ack);
  assign st_dup   = rv && (rseq == it_seq);
  assign st_free  = r_in && !recv_vld[ri] && !fcur;
  assign stale    = rv && behind(rseq, expected_seq);
  assign hit      = rv && (rseq == expected_seq);
  assign sd_free  = s_in && !send_vld[si] && !fcur;

  assign is_scan = (cmd == CMD_SCAN_OLD) || (cmd == CMD_SCAN_ACK) ||
                   (cmd == CMD_SCAN_STORE) || (cmd == CMD_SCAN_DELIV) ||
                   (cmd == CMD_SCAN_SEND);
  assign scan_done = is_scan && (cnt == IDXW'(SCAN_N - 1));

  // Duplicate ack count and fast retransmit trigger.
  logic [3:0] dup_new;
  assign dup_new = (it_ack == last_ack) ? ((dup_count == DUP_MAX) ? DUP_MAX : dup_count + 4'd1)
                                        : 4'd1;

  // Window rooms.
  logic [15:0] send_room_now, recv_room;
  assign send_room_now = (send_bytes >= window_bytes) ? 16'd0 : window_bytes - send_bytes;
  assign recv_room     = (recv_bytes >= window_bytes) ? 16'd0 : window_bytes - recv_bytes;

  // Outgoing length clamp and the room left after a new segment.
  logic [10:0] tx_clamp, tx_len;
  logic [15:0] sb_new, sb_eff, room_after;
  logic        take_send, pure_ack;
  assign tx_clamp   = (it_txlen > max_segment) ? max_segment : it_txlen;
  assign tx_len     = ({5'd0, tx_clamp} > send_room_now) ? send_room_now[10:0] : tx_clamp;
  assign take_send  = (tx_len != 11'd0) && found;
  assign pure_ack   = ((it_txlen == 11'd0) && flag) || (send_room_now == 16'd0) ||
                      ((tx_len != 11'd0) && !found);
  assign sb_new     = send_bytes + {5'd0, tx_len};
  assign sb_eff     = take_send ? sb_new : send_bytes;
  assign room_after = (sb_eff >= window_bytes) ? 16'd0 : window_bytes - sb_eff;

  // Result selection.
  assign out_free = !out_valid || out_ready;
  assign go       = !pend_valid || out_free;
  assign flush    = (cmd == CMD_FINISH) && go;

  always_comb begin
    res  = '{action: ACT_PURE_ACK, seg_seq: 32'd0, seg_length: 11'd0,
             ack_num: expected_seq, send_room: send_room_now};
    push = 1'b0;
    case (cmd)
      CMD_EMIT_OLD: begin
        push = go && found;
        res  = '{action: ACT_RETX, seg_seq: cap_seq, seg_length: cap_len,
                 ack_num: expected_seq, send_room: send_room_now};
      end
      CMD_EMIT_DELIV: begin
        push = go;
        res  = '{action: ACT_DELIVER, seg_seq: expected_seq, seg_length: cap_len,
                 ack_num: expected_seq + {21'd0, cap_len}, send_room: send_room_now};
      end
      CMD_EMIT_SEND: begin
        push = go && (take_send || pure_ack);
        if (take_send) begin
          res = '{action: ACT_SEND, seg_seq: next_seq, seg_length: tx_len,
                  ack_num: expected_seq, send_room: room_after};
        end else begin
          res = '{action: ACT_PURE_ACK, seg_seq: 32'd0, seg_length: 11'd0,
                  ack_num: expected_seq, send_room: send_room_now};
        end
      end
      default: ;
    endcase
  end

  // Status to the controller.
  always_comb begin
    st.scan_done = scan_done;
    st.found     = hit || fcur;
    st.fire      = dup_new >= dup_threshold;
    st.is_hdr    = (it_func == FUNC_HEADER);
    st.store_ok  = (it_rxlen != 11'd0) && (recv_room >= {5'd0, it_rxlen});
    st.emit_ok   = go;
  end

  // Control state: configuration, valid bits, counters and handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes  <= RST_WINDOW_BYTES;
      dup_threshold <= RST_DUP_THRESHOLD;
      max_segment   <= RST_MAX_SEGMENT;
      send_vld      <= '0;
      recv_vld      <= '0;
      send_bytes    <= 16'd0;
      recv_bytes    <= 16'd0;
      expected_seq  <= RST_INIT_EXP_SEQ;
      next_seq      <= RST_INIT_SEND_SEQ;
      last_ack      <= 32'd0;
      dup_count     <= 4'd1;
      cnt           <= '0;
      found         <= 1'b0;
      flag          <= 1'b0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INIT_SEND_SEQ: next_seq      <= cfg_data;
          REG_INIT_EXP_SEQ:  expected_seq  <= cfg_data;
          REG_WINDOW_BYTES:  window_bytes  <= cfg_data[15:0];
          REG_DUP_THRESHOLD: dup_threshold <= cfg_data[3:0];
          REG_MAX_SEGMENT:   max_segment   <= cfg_data[10:0];
          default: ;
        endcase
      end

      if (is_scan) cnt <= scan_done ? '0 : cnt + 1'b1;

      case (cmd)
        CMD_DUP: begin
          dup_count <= st.fire ? 4'd0 : dup_new;
          last_ack  <= it_ack;
        end
        CMD_SCAN_OLD: found <= take_old || fcur;
        CMD_SCAN_ACK: begin
          if (ack_drop) begin
            send_vld[si] <= 1'b0;
            send_bytes   <= (send_bytes >= {5'd0, slen}) ? send_bytes - {5'd0, slen} : 16'd0;
          end
        end
        CMD_SCAN_STORE: begin
          found <= st_free || fcur;
          flag  <= st_dup || gcur;
        end
        CMD_WRITE_STORE: begin
          if (found && !flag) begin
            recv_vld[idx[RW-1:0]] <= 1'b1;
            recv_bytes            <= recv_bytes + {5'd0, it_rxlen};
          end
        end
        CMD_SCAN_DELIV: begin
          found <= hit || fcur;
          if (stale) begin
            recv_vld[ri] <= 1'b0;
            recv_bytes   <= (recv_bytes >= {5'd0, rlen}) ? recv_bytes - {5'd0, rlen} : 16'd0;
          end
        end
        CMD_EMIT_DELIV: begin
          if (go) begin
            recv_vld[idx[RW-1:0]] <= 1'b0;
            recv_bytes   <= (recv_bytes >= {5'd0, cap_len}) ?
                            recv_bytes - {5'd0, cap_len} : 16'd0;
            expected_seq <= expected_seq + {21'd0, cap_len};
          end
        end
        CMD_SCAN_SEND: begin
          found <= sd_free || fcur;
          flag  <= rv || gcur;
        end
        CMD_EMIT_SEND: begin
          if (go && take_send) begin
            send_vld[idx[SW-1:0]] <= 1'b1;
            send_bytes            <= sb_new;
            next_seq              <= next_seq + {21'd0, tx_len};
          end
        end
        default: ;
      endcase

      // Result staging: one result is held back until the next shows
      // whether it is the last of its item.
      if (push) begin
        pend_valid <= 1'b1;
      end else if (flush && pend_valid) begin
        pend_valid <= 1'b0;
      end
      if ((push || flush) && pend_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: tables, item, captures and results.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_func  <= in_user;
      it_ack   <= in_data[32:1];
      it_seq   <= in_data[64:33];
      it_rxlen <= in_data[75:65];
      it_txlen <= in_data[86:76];
    end
    if (cmd == CMD_SCAN_OLD && take_old) begin
      idx      <= cnt;
      best_gap <= d;
      cap_seq  <= sseq;
      cap_len  <= slen;
    end
    if (cmd == CMD_SCAN_STORE && st_free) idx <= cnt;
    if (cmd == CMD_SCAN_DELIV && hit) begin
      idx     <= cnt;
      cap_len <= rlen;
    end
    if (cmd == CMD_SCAN_SEND && sd_free) idx <= cnt;
    if (cmd == CMD_WRITE_STORE && found && !flag) begin
      recv_seq[idx[RW-1:0]] <= it_seq;
      recv_len[idx[RW-1:0]] <= it_rxlen;
    end
    if (cmd == CMD_EMIT_SEND && go && take_send) begin
      send_seq[idx[SW-1:0]] <= next_seq;
      send_len[idx[SW-1:0]] <= tx_len;
    end
    if (push) begin
      pend <= res;
      if (pend_valid) begin
        out_res  <= pend;
        out_last <= 1'b0;
      end
    end else if (flush && pend_valid) begin
      out_res  <= pend;
      out_last <= 1'b1;
    end
  end

  assign out_data = {5'd0, out_res.send_room, out_res.ack_num,
                     out_res.seg_length, out_res.seg_seq};
  assign out_user = out_res.action;

  // A new result never overwrites an output that is still waiting.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push && pend_valid |-> out_free)
    else $error("result pushed while output register is occupied");

  // A stored segment only goes into a free reorder slot.
  a_store_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_WRITE_STORE) && found && !flag |-> !recv_vld[idx[RW-1:0]])
    else $error("reorder write into an occupied slot");

  // A new segment only goes into a free send slot.
  a_send_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_EMIT_SEND) && go && take_send |-> !send_vld[idx[SW-1:0]])
    else $error("send table write into an occupied slot");

endmodule

// ===== hdl/reliable_transport_window_engine.sv =====
// Top level of the reliable transport window engine.
//
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tdata header/send fields, tuser func
//  m_axis    out        m_axis_tvalid/tready    tdata segment fields, tuser action, tlast
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One item is worked at a time; every table pass walks N = max(SEND_SLOTS, RECV_SLOTS)
// entries, one per cycle. Timeout: oldest pass, resend. Send: free-slot pass, emit. Header:
// dup check, optional resend, ack pass, optional store and write, delivery passes; then finish.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled output holds the engine at its next result; input is taken only when idle.
module reliable_transport_window_engine
  import rtwe_pkg::*;
#(
  parameter int SEND_SLOTS = 32,
  parameter int RECV_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rx_ack_flag, rx_ack_num, rx_seq, rx_length, tx_length, zero pad
  input  logic [87:0] s_axis_tdata,
  // func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // seg_seq, seg_length, ack_num, send_room, zero pad
  output logic [95:0] m_axis_tdata,
  // action
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  rtwe_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_func     (s_axis_tuser),
    .in_ack_flag (s_axis_tdata[0]),
    .st          (st),
    .in_ready    (s_axis_tready),
    .cmd         (cmd)
  );

  rtwe_datapath #(
    .SEND_SLOTS (SEND_SLOTS),
    .RECV_SLOTS (RECV_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_accept (s_axis_tvalid && s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the reliable transport window engine.
module tb_top;
  import rtwe_pkg::*;

  // One input item and one result, at the widths of the block.
  typedef struct packed {
    logic [1:0]  func;
    logic        ack_flag;
    logic [31:0] ack_num;
    logic [31:0] rx_seq;
    logic [10:0] rx_len;
    logic [10:0] tx_len;
  } hdr_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] seg_seq;
    logic [10:0] seg_len;
    logic [31:0] ack_num;
    logic [15:0] room;
    logic        last;
  } seg_res_t;

  // Directed row: the item, and a hand-typed result where one is obvious.
  typedef struct packed {
    hdr_item_t item;
    logic      typed;
    seg_res_t  res;
  } dir_row_t;

  localparam int SLOTS = 32;
  localparam int SETTLE = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  reliable_transport_window_engine u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the engine state.
  logic [31:0] cfg_isn, cfg_ies;
  logic [15:0] cfg_win;
  logic [3:0]  cfg_thr;
  logic [10:0] cfg_mss;
  logic [31:0] snd_seq [SLOTS];
  logic [10:0] snd_len [SLOTS];
  logic        snd_vld [SLOTS];
  logic [31:0] rcv_seq [SLOTS];
  logic [10:0] rcv_len [SLOTS];
  logic        rcv_vld [SLOTS];
  int unsigned snd_bytes, rcv_bytes;
  logic [31:0] exp_seq, nxt_seq, last_ack;
  logic [3:0]  dup_cnt;

  seg_res_t  pending_q[$];
  seg_res_t  step_q[$];
  int        errors = 0;
  int        n_items = 0;
  int        n_results = 0;
  logic      cur_typed = 1'b0;
  seg_res_t  cur_res;

  function automatic logic lags(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic [15:0] send_room_now();
    return (snd_bytes >= cfg_win) ? 16'd0 : 16'(cfg_win - snd_bytes);
  endfunction

  task automatic push_seg(logic [1:0] act, logic [31:0] sq, logic [10:0] ln);
    seg_res_t r;
    r = '{act, sq, ln, exp_seq, send_room_now(), 1'b0};
    step_q = {step_q, r};
  endtask

  task automatic resend_oldest();
    int best;
    logic [31:0] bestd, d;
    best = -1;
    bestd = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (snd_vld[i]) begin
        d = nxt_seq - snd_seq[i];
        if (best < 0 || d > bestd) begin
          best = i;
          bestd = d;
        end
      end
    end
    if (best >= 0) push_seg(ACT_RETX, snd_seq[best], snd_len[best]);
  endtask

  task automatic drop_behind();
    for (int i = 0; i < SLOTS; i++) begin
      if (rcv_vld[i] && lags(rcv_seq[i], exp_seq)) begin
        rcv_vld[i] = 1'b0;
        rcv_bytes = (rcv_bytes >= rcv_len[i]) ? rcv_bytes - rcv_len[i] : 0;
      end
    end
  endtask

  task automatic take_header(hdr_item_t it);
    int unsigned room, ln;
    int free_slot, hit;
    logic dup;
    if (it.ack_num == last_ack) begin
      if (dup_cnt < DUP_MAX) dup_cnt++;
    end else begin
      dup_cnt = 4'd1;
    end
    if (dup_cnt >= cfg_thr) begin
      resend_oldest();
      dup_cnt = 4'd0;
    end
    last_ack = it.ack_num;
    for (int i = 0; i < SLOTS; i++) begin
      if (snd_vld[i] && lags(snd_seq[i], it.ack_num)) begin
        snd_vld[i] = 1'b0;
        snd_bytes = (snd_bytes >= snd_len[i]) ? snd_bytes - snd_len[i] : 0;
      end
    end
    room = (rcv_bytes >= cfg_win) ? 0 : cfg_win - rcv_bytes;
    ln = it.rx_len;
    if (ln > 0 && room >= ln) begin
      free_slot = -1;
      dup = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (rcv_vld[i]) begin
          if (rcv_seq[i] == it.rx_seq) dup = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (!dup && free_slot >= 0) begin
        rcv_seq[free_slot] = it.rx_seq;
        rcv_len[free_slot] = it.rx_len;
        rcv_vld[free_slot] = 1'b1;
        rcv_bytes += ln;
      end
    end
    drop_behind();
    // Deliver while a stored segment starts at the expected sequence.
    for (int k = 0; k < SLOTS; k++) begin
      hit = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && rcv_vld[i] && rcv_seq[i] == exp_seq) hit = i;
      end
      if (hit < 0) break;
      rcv_vld[hit] = 1'b0;
      rcv_bytes = (rcv_bytes >= rcv_len[hit]) ? rcv_bytes - rcv_len[hit] : 0;
      exp_seq += rcv_len[hit];
      push_seg(ACT_DELIVER, rcv_seq[hit], rcv_len[hit]);
      drop_behind();
    end
  endtask

  task automatic take_send(hdr_item_t it);
    int unsigned room, ln;
    int free_slot;
    logic held;
    room = send_room_now();
    ln = it.tx_len;
    if (ln > cfg_mss) ln = cfg_mss;
    if (ln > room) ln = room;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) if (free_slot < 0 && !snd_vld[i]) free_slot = i;
    held = 1'b0;
    for (int i = 0; i < SLOTS; i++) if (rcv_vld[i]) held = 1'b1;
    if (ln > 0 && free_slot >= 0) begin
      snd_seq[free_slot] = nxt_seq;
      snd_len[free_slot] = 11'(ln);
      snd_vld[free_slot] = 1'b1;
      snd_bytes += ln;
      nxt_seq += ln;
      push_seg(ACT_SEND, nxt_seq - ln, 11'(ln));
    end else if ((it.tx_len == 0 && held) || room == 0 || (ln > 0 && free_slot < 0)) begin
      push_seg(ACT_PURE_ACK, 32'd0, 11'd0);
    end
  endtask

  // Works out the results of one accepted item into step_q.
  task automatic predict_segments(hdr_item_t it);
    step_q.delete();
    case (it.func)
      FUNC_HEADER:  if (it.ack_flag) take_header(it);
      FUNC_TIMEOUT: resend_oldest();
      FUNC_SEND:    take_send(it);
      default: ;
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endtask

  task automatic apply_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_INIT_SEND_SEQ: begin cfg_isn = val; nxt_seq = val; end
      REG_INIT_EXP_SEQ:  begin cfg_ies = val; exp_seq = val; end
      REG_WINDOW_BYTES:  cfg_win = val[15:0];
      REG_DUP_THRESHOLD: cfg_thr = val[3:0];
      REG_MAX_SEGMENT:   cfg_mss = val[10:0];
      default: ;
    endcase
  endtask

  initial begin
    cfg_isn = RST_INIT_SEND_SEQ;
    cfg_ies = RST_INIT_EXP_SEQ;
    cfg_win = RST_WINDOW_BYTES;
    cfg_thr = RST_DUP_THRESHOLD;
    cfg_mss = RST_MAX_SEGMENT;
    for (int i = 0; i < SLOTS; i++) begin
      snd_vld[i] = 1'b0;
      rcv_vld[i] = 1'b0;
    end
    snd_bytes = 0;
    rcv_bytes = 0;
    exp_seq = RST_INIT_EXP_SEQ;
    nxt_seq = RST_INIT_SEND_SEQ;
    last_ack = '0;
    dup_cnt = 4'd1;
  end

  // Checks result transactions, predicts on accepted input transactions and follows config writes.
  always @(posedge clk) begin
    seg_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[42:32],
              m_axis_tdata[74:43], m_axis_tdata[90:75], m_axis_tlast};
      n_results++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: mismatch exp no result, act %h", $time, got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch exp act=%0d seq=%h len=%0d ack=%h room=%0d last=%b",
                   $time, want.action, want.seg_seq, want.seg_len, want.ack_num,
                   want.room, want.last);
          $display("%0t:          act act=%0d seq=%h len=%0d ack=%h room=%0d last=%b",
                   $time, got.action, got.seg_seq, got.seg_len, got.ack_num,
                   got.room, got.last);
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      n_items++;
      predict_segments('{s_axis_tuser, s_axis_tdata[0], s_axis_tdata[32:1],
                         s_axis_tdata[64:33], s_axis_tdata[75:65], s_axis_tdata[86:76]});
      if (cur_typed) pending_q = {pending_q, cur_res};
      else foreach (step_q[i]) pending_q = {pending_q, step_q[i]};
    end
    if (!rst && cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
  end

  // Receiver readiness steps through four patterns: always ready, random, one in four, on/off.
  int unsigned cyc = 0;
  always @(negedge clk) begin
    cyc++;
    case ((cyc / 500) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((cyc % 37) < 30);
    endcase
  end

  // Sender: bursts of transactions with random gaps between them.
  int burst_left = 0;
  task automatic send_item(hdr_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tuser <= it.func;
    s_axis_tdata <= {1'b0, it.tx_len, it.rx_len, it.rx_seq, it.ack_num, it.ack_flag};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_regs(logic [31:0] isn, logic [31:0] ies, logic [15:0] win,
                            logic [3:0] thr, logic [10:0] mss);
    logic [31:0] vals [5];
    vals = '{isn, ies, 32'(win), 32'(thr), 32'(mss)};
    for (int i = 0; i < 5; i++) begin
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Lowers the sender, waits for every expected result, then lets the engine settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly well-formed traffic around the current sequence state, with some noise.
  function automatic hdr_item_t make_item(int unsigned seg);
    hdr_item_t it;
    int unsigned r, k;
    it = '{FUNC_HEADER, 1'b1, last_ack, exp_seq, 11'(seg), 11'($urandom_range(0, 2047))};
    r = $urandom_range(0, 99);
    if (r < 30) begin
      it.func = FUNC_SEND;
      case ($urandom_range(0, 4))
        0: it.tx_len = 11'd0;
        1: it.tx_len = 11'd2047;
        default: it.tx_len = 11'($urandom_range(1, 400));
      endcase
    end else if (r < 75) begin
      case ($urandom_range(0, 4))
        0: it.ack_num = nxt_seq;
        1: it.ack_num = last_ack;
        2: it.ack_num = $urandom;
        default: begin
          k = $urandom_range(0, SLOTS - 1);
          if (snd_vld[k]) it.ack_num = snd_seq[k] + snd_len[k];
        end
      endcase
      case ($urandom_range(0, 5))
        0: it.rx_seq = $urandom;
        1: it.rx_len = 11'($urandom_range(0, 2047));
        default: it.rx_seq = exp_seq + seg * $urandom_range(0, 4);
      endcase
    end else if (r < 87) begin
      it.func = FUNC_TIMEOUT;
      it.ack_num = $urandom;
    end else if (r < 93) begin
      it.func = 2'd3;
      it.rx_seq = $urandom;
    end else begin
      it.ack_flag = 1'b0;
      it.ack_num = $urandom;
      it.rx_seq = $urandom;
    end
    return it;
  endfunction

  dir_row_t dir_rows [14];
  initial begin
    dir_rows = '{
      '{'{FUNC_SEND, 1'b0, 32'd0, 32'd0, 11'd0, 11'd10}, 1'b1,
        '{ACT_SEND, 32'd100, 11'd10, 32'd0, 16'd20230, 1'b1}},
      '{'{FUNC_SEND, 1'b0, 32'd0, 32'd0, 11'd0, 11'd2047}, 1'b1,
        '{ACT_SEND, 32'd110, 11'd1012, 32'd0, 16'd19218, 1'b1}},
      '{'{FUNC_HEADER, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047, 11'd2047}, 1'b0, '0},
      '{'{2'd3, 1'b1, 32'd0, 32'd0, 11'd5, 11'd5}, 1'b0, '0},
      '{'{FUNC_TIMEOUT, 1'b0, 32'd0, 32'd0, 11'd0, 11'd0}, 1'b1,
        '{ACT_RETX, 32'd100, 11'd10, 32'd0, 16'd19218, 1'b1}},
      '{'{FUNC_HEADER, 1'b1, 32'd0, 32'd0, 11'd0, 11'd0}, 1'b0, '0},
      '{'{FUNC_HEADER, 1'b1, 32'd0, 32'd0, 11'd0, 11'd0}, 1'b1,
        '{ACT_RETX, 32'd100, 11'd10, 32'd0, 16'd19218, 1'b1}},
      '{'{FUNC_HEADER, 1'b1, 32'd110, 32'd0, 11'd50, 11'd0}, 1'b1,
        '{ACT_DELIVER, 32'd0, 11'd50, 32'd50, 16'd19228, 1'b1}},
      '{'{FUNC_HEADER, 1'b1, 32'd1122, 32'd100, 11'd20, 11'd0}, 1'b0, '0},
      '{'{FUNC_SEND, 1'b0, 32'd0, 32'd0, 11'd0, 11'd0}, 1'b1,
        '{ACT_PURE_ACK, 32'd0, 11'd0, 32'd50, 16'd20240, 1'b1}},
      '{'{FUNC_HEADER, 1'b1, 32'd1122, 32'd50, 11'd50, 11'd0}, 1'b0, '0},
      '{'{FUNC_TIMEOUT, 1'b1, 32'd0, 32'd0, 11'd0, 11'd0}, 1'b0, '0},
      '{'{FUNC_SEND, 1'b0, 32'd0, 32'd0, 11'd0, 11'd0}, 1'b0, '0},
      '{'{FUNC_HEADER, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd2047, 11'd2047}, 1'b0, '0}
    };
  end

  // Register settings of the random phases, extremes included.
  logic [31:0] ph_isn [4];
  logic [31:0] ph_ies [4];
  logic [15:0] ph_win [4];
  logic [3:0]  ph_thr [4];
  logic [10:0] ph_mss [4];

  initial begin
    int unsigned seg;
    ph_isn = '{32'hFFFF_FF00, $urandom, 32'd0, 32'hFFFF_FFFF};
    ph_ies = '{32'hFFFF_FFF0, $urandom, 32'h8000_0000, 32'hFFFF_FFFF};
    ph_win = '{16'd65535, 16'd1, 16'd3000, RST_WINDOW_BYTES};
    ph_thr = '{4'd1, 4'd15, 4'd2, RST_DUP_THRESHOLD};
    ph_mss = '{11'd2047, 11'd1, 11'd300, RST_MAX_SEGMENT};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows run at the reset settings.
    foreach (dir_rows[i]) begin
      cur_typed = dir_rows[i].typed;
      cur_res = dir_rows[i].res;
      send_item(dir_rows[i].item);
    end
    cur_typed = 1'b0;

    for (int p = 0; p < 4; p++) begin
      drain();
      write_regs(ph_isn[p], ph_ies[p], ph_win[p], ph_thr[p], ph_mss[p]);
      @(negedge clk);
      seg = $urandom_range(1, (ph_win[p] < 300) ? ph_win[p] : 300);
      for (int j = 0; j < 60; j++) begin
        // Hold off halfway through until the engine has caught up.
        if (j == 30) drain();
        send_item(make_item(seg));
      end
    end

    drain();
    $display("Run covered %0d input items and %0d results over 5 register settings.",
             n_items, n_results);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
